@@ hdl/gmds_pkg.sv @@
// shared constants and types for the grid maze depth-first solver
package gmds_pkg;

  // maze geometry
  localparam int MaxRows    = 64;
  localparam int MaxCols    = 64;
  localparam int RowW       = 6;
  localparam int ColW       = 6;
  localparam int CellAddrW  = RowW + ColW;
  localparam int CellTotal  = MaxRows * MaxCols;
  localparam int CountW     = 7;

  // explicit stack
  localparam int StackDepth = 16384;
  localparam int StackAddrW = $clog2(StackDepth);
  localparam int SpW        = StackAddrW + 1;
  localparam int VisitW     = 15;
  localparam int VisitCap   = 16384;

  // stored cell codes
  localparam logic [1:0] CodeWall = 2'd0;
  localparam logic [1:0] CodePath = 2'd1;
  localparam logic [1:0] CodeExit = 2'd2;
  localparam logic [1:0] CodeSeen = 2'd3;

  // raw maze characters
  localparam logic [7:0] CharPath  = 8'h78;  // x
  localparam logic [7:0] CharExit  = 8'h73;  // s
  localparam logic [7:0] CharStart = 8'h65;  // e
  localparam logic [7:0] CharSeen  = 8'h2e;  // .

  // item commands
  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdSearch = 1'b1;

  // result status codes
  localparam logic [1:0] StatusDone     = 2'd0;
  localparam logic [1:0] StatusNoStart  = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  // configuration register indexes
  localparam logic CfgRowCount    = 1'b0;
  localparam logic CfgColumnCount = 1'b1;

  typedef struct packed {
    logic              goal_reached;
    logic [1:0]        status;
    logic [VisitW-1:0] cells_visited;
  } result_t;

endpackage

@@ hdl/grid_maze_dfs_solver_top.sv @@
// top level of the grid maze depth-first solver: ports, config and result register
// load item: writes the cell store, no result; the walker stays idle, next item next cycle
// search item: seeds the stack, then reads and checks each popped cell, steps its neighbor
//   slots and reads in-bounds neighbors; bound by the single read port of the cell store
// in_ready_o stays low from the search item until its result is handed to the output register
// reset clears control and the start marker, sets the count registers to 64 rows, 64 columns;
//   cell store and stack are not cleared and are undefined until written
module grid_maze_dfs_solver_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [gmds_pkg::CountW-1:0]        cfg_data_i,
  // item input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               command_i,
  input  logic [gmds_pkg::RowW-1:0]          cell_row_i,
  input  logic [gmds_pkg::ColW-1:0]          cell_column_i,
  input  logic [7:0]                         cell_char_i,
  // result output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               goal_reached_o,
  output logic [1:0]                         status_o,
  output logic [gmds_pkg::VisitW-1:0]        cells_visited_o
);

  logic [gmds_pkg::CountW-1:0] row_count_q, row_count_d;
  logic [gmds_pkg::CountW-1:0] column_count_q, column_count_d;
  logic                        out_valid_q, out_valid_d;
  gmds_pkg::result_t           result_q, result_d;

  logic                        item_accept;
  logic                        walker_idle;
  logic                        res_valid;
  logic                        out_free;
  gmds_pkg::result_t           res;

  // config writes are always taken; the user must send them only while the block is idle, it does not enforce this
  assign cfg_ready_o = 1'b1;

  always_comb begin
    row_count_d    = row_count_q;
    column_count_d = column_count_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gmds_pkg::CfgRowCount:    row_count_d    = cfg_data_i;
        gmds_pkg::CfgColumnCount: column_count_d = cfg_data_i;
        default:                  row_count_d    = row_count_q;
      endcase
    end
  end

  // the walker takes items only from its idle state
  assign in_ready_o  = walker_idle;
  assign item_accept = in_valid_i && in_ready_o;

  // output register frees up in the same cycle it is taken
  assign out_free = !out_valid_q || out_ready_i;

  gmds_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_accept_i (item_accept),
    .command_i     (command_i),
    .cell_row_i    (cell_row_i),
    .cell_column_i (cell_column_i),
    .cell_char_i   (cell_char_i),
    .row_count_i   (row_count_q),
    .column_count_i(column_count_q),
    .out_free_i    (out_free),
    .idle_o        (walker_idle),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // result holding register, parts the walker from the consumer
  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
      result_d    = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= gmds_pkg::CountW'(gmds_pkg::MaxRows);
      column_count_q <= gmds_pkg::CountW'(gmds_pkg::MaxCols);
      out_valid_q    <= 1'b0;
    end else begin
      row_count_q    <= row_count_d;
      column_count_q <= column_count_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o     = out_valid_q;
  assign goal_reached_o  = result_q.goal_reached;
  assign status_o        = result_q.status;
  assign cells_visited_o = result_q.cells_visited;

`ifndef SYNTHESIS
  // a search item blocks further items on the next cycle
  a_search_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_accept && command_i == gmds_pkg::CmdSearch) |=> !in_ready_o)
    else $error("input still ready after a search item");

  // found only comes with a plain done status
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && goal_reached_o) |-> (status_o == gmds_pkg::StatusDone))
    else $error("exit found with an error status");

  // no start means no visits
  a_nostart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == gmds_pkg::StatusNoStart) |-> (cells_visited_o == '0))
    else $error("visits reported without a start cell");

  // the visit count saturates at its cap
  a_visit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cells_visited_o <= gmds_pkg::VisitW'(gmds_pkg::VisitCap)))
    else $error("visit count beyond its cap");

  // a new result never lands on a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result register overwritten");
`endif

endmodule

@@ hdl/gmds_ram.sv @@
// generic single write, single read port ram with registered read data
module gmds_ram #(
  parameter int Depth = 4096,
  parameter int Width = 2,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/gmds_walker.sv @@
// cell loader and depth-first walk sequencer with cell store and stack
module gmds_walker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_accept_i,
  input  logic                              command_i,
  input  logic [gmds_pkg::RowW-1:0]         cell_row_i,
  input  logic [gmds_pkg::ColW-1:0]         cell_column_i,
  input  logic [7:0]                        cell_char_i,
  input  logic [gmds_pkg::CountW-1:0]       row_count_i,
  input  logic [gmds_pkg::CountW-1:0]       column_count_i,
  input  logic                              out_free_i,
  output logic                              idle_o,
  output logic                              res_valid_o,
  output gmds_pkg::result_t                 res_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPop   = 3'd1;
  localparam logic [2:0] StCell  = 3'd2;
  localparam logic [2:0] StCheck = 3'd3;
  localparam logic [2:0] StNbRd  = 3'd4;
  localparam logic [2:0] StNbChk = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  localparam logic [1:0] NbUp    = 2'd0;
  localparam logic [1:0] NbDown  = 2'd1;
  localparam logic [1:0] NbLeft  = 2'd2;
  localparam logic [1:0] NbRight = 2'd3;

  localparam int CW = gmds_pkg::CountW;
  localparam int AW = gmds_pkg::CellAddrW;
  localparam int SW = gmds_pkg::SpW;
  localparam int VW = gmds_pkg::VisitW;

  logic [2:0]                          state_q, state_d;
  logic [SW-1:0]                       sp_q, sp_d;
  logic [VW-1:0]                       visit_q, visit_d;
  logic [AW-1:0]                       start_q, start_d;
  logic                                start_seen_q, start_seen_d;
  logic [AW-1:0]                       cur_q, cur_d;
  logic [AW-1:0]                       nb_addr_q, nb_addr_d;
  logic [1:0]                          nbr_q, nbr_d;
  logic                                found_q, found_d;
  logic [1:0]                          status_q, status_d;

  logic                                cell_we;
  logic [AW-1:0]                       cell_waddr, cell_raddr;
  logic [1:0]                          cell_wdata, cell_rdata;
  logic                                stk_we;
  logic [gmds_pkg::StackAddrW-1:0]     stk_waddr, stk_raddr;
  logic [AW-1:0]                       stk_wdata, stk_rdata;

  logic [CW-1:0]                       rows, cols;
  logic [CW-1:0]                       nb_row, nb_col;
  logic                                nb_ok;
  logic [1:0]                          load_code;
  logic [SW-1:0]                       sp_dec;

  gmds_ram #(
    .Depth(gmds_pkg::CellTotal),
    .Width(2)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (cell_we),
    .waddr_i(cell_waddr),
    .wdata_i(cell_wdata),
    .raddr_i(cell_raddr),
    .rdata_o(cell_rdata)
  );

  gmds_ram #(
    .Depth(gmds_pkg::StackDepth),
    .Width(AW)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // clamp the counts in use to 1..max
  always_comb begin
    if (row_count_i == '0) begin
      rows = CW'(1);
    end else if (row_count_i > CW'(gmds_pkg::MaxRows)) begin
      rows = CW'(gmds_pkg::MaxRows);
    end else begin
      rows = row_count_i;
    end
    if (column_count_i == '0) begin
      cols = CW'(1);
    end else if (column_count_i > CW'(gmds_pkg::MaxCols)) begin
      cols = CW'(gmds_pkg::MaxCols);
    end else begin
      cols = column_count_i;
    end
  end

  // character to stored code
  always_comb begin
    unique case (cell_char_i)
      gmds_pkg::CharPath: load_code = gmds_pkg::CodePath;
      gmds_pkg::CharExit: load_code = gmds_pkg::CodeExit;
      gmds_pkg::CharSeen: load_code = gmds_pkg::CodeSeen;
      default:            load_code = gmds_pkg::CodeWall;
    endcase
  end

  // shared neighbor step: one offset and one bounds compare per cycle
  always_comb begin
    nb_row = {1'b0, cur_q[AW-1 -: gmds_pkg::RowW]};
    nb_col = {1'b0, cur_q[gmds_pkg::ColW-1:0]};
    nb_ok  = 1'b1;
    unique case (nbr_q)
      NbUp: begin
        nb_ok  = (nb_row != '0);
        nb_row = nb_row - CW'(1);
      end
      NbDown: begin
        nb_row = nb_row + CW'(1);
      end
      NbLeft: begin
        nb_ok  = (nb_col != '0);
        nb_col = nb_col - CW'(1);
      end
      NbRight: begin
        nb_col = nb_col + CW'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
    nb_ok = nb_ok && (nb_row < rows) && (nb_col < cols);
  end

  assign sp_dec = sp_q - SW'(1);

  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    visit_d      = visit_q;
    start_d      = start_q;
    start_seen_d = start_seen_q;
    cur_d        = cur_q;
    nb_addr_d    = nb_addr_q;
    nbr_d        = nbr_q;
    found_d      = found_q;
    status_d     = status_q;
    cell_we      = 1'b0;
    cell_waddr   = {cell_row_i, cell_column_i};
    cell_wdata   = load_code;
    cell_raddr   = stk_rdata;
    stk_we       = 1'b0;
    stk_waddr    = sp_q[gmds_pkg::StackAddrW-1:0];
    stk_wdata    = nb_addr_q;
    stk_raddr    = sp_dec[gmds_pkg::StackAddrW-1:0];
    res_valid_o  = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (item_accept_i) begin
          if (command_i == gmds_pkg::CmdLoad) begin
            cell_we = 1'b1;
            if (cell_char_i == gmds_pkg::CharStart) begin
              start_d      = {cell_row_i, cell_column_i};
              start_seen_d = 1'b1;
            end
          end else begin
            visit_d  = '0;
            found_d  = 1'b0;
            status_d = gmds_pkg::StatusDone;
            if (!start_seen_q) begin
              sp_d     = '0;
              status_d = gmds_pkg::StatusNoStart;
              state_d  = StDone;
            end else begin
              // seed the stack with the start cell
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = start_q;
              sp_d      = SW'(1);
              state_d   = StPop;
            end
          end
        end
      end
      StPop: begin
        if (sp_q == '0) begin
          state_d = StDone;
        end else begin
          sp_d    = sp_dec;
          state_d = StCell;
        end
      end
      StCell: begin
        cell_raddr = stk_rdata;
        cur_d      = stk_rdata;
        state_d    = StCheck;
      end
      StCheck: begin
        if (cell_rdata == gmds_pkg::CodeExit) begin
          found_d = 1'b1;
          state_d = StDone;
        end else begin
          cell_we    = 1'b1;
          cell_waddr = cur_q;
          cell_wdata = gmds_pkg::CodeSeen;
          if (visit_q != VW'(gmds_pkg::VisitCap)) begin
            visit_d = visit_q + VW'(1);
          end
          nbr_d   = NbUp;
          state_d = StNbRd;
        end
      end
      StNbRd: begin
        if (nb_ok) begin
          cell_raddr = {nb_row[gmds_pkg::RowW-1:0], nb_col[gmds_pkg::ColW-1:0]};
          nb_addr_d  = {nb_row[gmds_pkg::RowW-1:0], nb_col[gmds_pkg::ColW-1:0]};
          state_d    = StNbChk;
        end else if (nbr_q == NbRight) begin
          state_d = StPop;
        end else begin
          nbr_d = nbr_q + 2'd1;
        end
      end
      StNbChk: begin
        if (cell_rdata == gmds_pkg::CodePath || cell_rdata == gmds_pkg::CodeExit) begin
          if (sp_q == SW'(gmds_pkg::StackDepth)) begin
            status_d = gmds_pkg::StatusOverflow;
            state_d  = StDone;
          end else begin
            stk_we  = 1'b1;
            sp_d    = sp_q + SW'(1);
          end
        end
        if (state_d != StDone) begin
          if (nbr_q == NbRight) begin
            state_d = StPop;
          end else begin
            nbr_d   = nbr_q + 2'd1;
            state_d = StNbRd;
          end
        end
      end
      StDone: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      sp_q         <= '0;
      visit_q      <= '0;
      start_q      <= '0;
      start_seen_q <= 1'b0;
      nbr_q        <= NbUp;
      found_q      <= 1'b0;
      status_q     <= gmds_pkg::StatusDone;
    end else begin
      state_q      <= state_d;
      sp_q         <= sp_d;
      visit_q      <= visit_d;
      start_q      <= start_d;
      start_seen_q <= start_seen_d;
      nbr_q        <= nbr_d;
      found_q      <= found_d;
      status_q     <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    nb_addr_q <= nb_addr_d;
  end

  assign idle_o              = (state_q == StIdle);
  assign res_o.goal_reached  = found_q;
  assign res_o.status        = status_q;
  assign res_o.cells_visited = visit_q;

endmodule
